>>> rtl/mqm_pkg.sv
// ----------------------------------------------------------------------------
// mqm_pkg
// Shared types and codes of the multi-queue mailbox: request actions, result
// status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mqm_pkg;

  localparam int unsigned QID_W        = 8;
  localparam int unsigned IN_HANDLE_W  = 16;
  localparam int unsigned OUT_HANDLE_W = 16;

  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_RECV  = 2'd1,
    ACT_PURGE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BADQ  = 3'd1,
    ST_NULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND,
    S_LINK,
    S_RECV_HEAD,
    S_RECV_POP,
    S_PQ_LOAD,
    S_P_RD,
    S_P_EVAL,
    S_P_FREE
  } state_e;

  typedef struct packed {
    status_e                  status;
    logic [OUT_HANDLE_W-1:0]  handle;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/mqm_ram.sv
// ----------------------------------------------------------------------------
// mqm_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mqm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mqm_seq.sv
// ----------------------------------------------------------------------------
// mqm_seq
// Request sequencer: walks send, receive and purge through the queue table
// and the entry pool memories, keeps the free list head and the bump mark.
// ----------------------------------------------------------------------------
`default_nettype none

module mqm_seq #(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned HANDLE_BITS = 16,
  localparam int unsigned LW = $clog2(ENTRIES + 1),
  localparam int unsigned AW = $clog2(ENTRIES),
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        action_i,
  input  wire logic [mqm_pkg::QID_W-1:0]         queue_id_i,
  input  wire logic [mqm_pkg::IN_HANDLE_W-1:0]   msg_handle_i,
  input  wire logic                              res_room_i,
  output logic                                   res_push_o,
  output mqm_pkg::result_t                       res_o,
  output logic                                   link_we_o,
  output logic [AW-1:0]                          link_waddr_o,
  output logic [LW-1:0]                          link_wdata_o,
  output logic [AW-1:0]                          link_raddr_o,
  input  wire logic [LW-1:0]                     link_rdata_i,
  output logic                                   hnd_we_o,
  output logic [AW-1:0]                          hnd_waddr_o,
  output logic [HANDLE_BITS-1:0]                 hnd_wdata_o,
  output logic [AW-1:0]                          hnd_raddr_o,
  input  wire logic [HANDLE_BITS-1:0]            hnd_rdata_i,
  output logic                                   qt_we_o,
  output logic [QW-1:0]                          qt_waddr_o,
  output logic [2*LW-1:0]                        qt_wdata_o,
  output logic [QW-1:0]                          qt_raddr_o,
  input  wire logic [2*LW-1:0]                   qt_rdata_i
);

  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  mqm_pkg::state_e state_q, state_d;

  logic [LW-1:0]          free_head_q, free_head_d;
  logic [LW-1:0]          unused_q, unused_d;
  logic [NUM_QUEUES-1:0]  qv_q, qv_d;
  logic [QW-1:0]          q_q, q_d;
  logic [HANDLE_BITS-1:0] h_q, h_d;
  logic [LW-1:0]          cur_q, cur_d;
  logic [LW-1:0]          prev_q, prev_d;
  logic [LW-1:0]          nxt_q, nxt_d;
  logic [LW-1:0]          head_q, head_d;
  logic [LW-1:0]          tail_q, tail_d;

  logic                   accept;
  mqm_pkg::action_e       act;
  logic                   qid_ok;
  logic [HANDLE_BITS-1:0] h_in;
  logic                   h_nz;
  logic [LW-1:0]          rd_head, rd_tail;
  logic                   fh_live, mark_live, avail;
  logic [LW-1:0]          send_e;
  logic                   last_q;
  logic                   match;

  assign in_ready_o = (state_q == mqm_pkg::S_IDLE) && res_room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign act        = mqm_pkg::action_e'(action_i);
  assign qid_ok     = {1'b0, queue_id_i} < (mqm_pkg::QID_W + 1)'(NUM_QUEUES);
  assign h_in       = HANDLE_BITS'(msg_handle_i);
  assign h_nz       = |h_in;

  // a queue never written reads as empty
  assign rd_head   = qv_q[q_q] ? qt_rdata_i[LW-1:0]    : NIL;
  assign rd_tail   = qv_q[q_q] ? qt_rdata_i[2*LW-1:LW] : NIL;
  assign fh_live   = free_head_q < NIL;
  assign mark_live = unused_q < NIL;
  assign avail     = fh_live || mark_live;
  assign send_e    = fh_live ? free_head_q : unused_q;
  assign last_q    = q_q == QW'(NUM_QUEUES - 1);
  assign match     = hnd_rdata_i == h_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mqm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (act)
            mqm_pkg::ACT_SEND:  if (qid_ok && h_nz) state_d = mqm_pkg::S_SEND;
            mqm_pkg::ACT_RECV:  if (qid_ok) state_d = mqm_pkg::S_RECV_HEAD;
            mqm_pkg::ACT_PURGE: if (h_nz) state_d = mqm_pkg::S_PQ_LOAD;
            default:            state_d = mqm_pkg::S_IDLE;
          endcase
        end
      end
      mqm_pkg::S_SEND: begin
        if (avail && (rd_head < NIL) && (rd_tail < NIL)) state_d = mqm_pkg::S_LINK;
        else state_d = mqm_pkg::S_IDLE;
      end
      mqm_pkg::S_LINK:      state_d = mqm_pkg::S_IDLE;
      mqm_pkg::S_RECV_HEAD: begin
        if (rd_head < NIL) state_d = mqm_pkg::S_RECV_POP;
        else state_d = mqm_pkg::S_IDLE;
      end
      mqm_pkg::S_RECV_POP:  state_d = mqm_pkg::S_IDLE;
      mqm_pkg::S_PQ_LOAD:   state_d = mqm_pkg::S_P_RD;
      mqm_pkg::S_P_RD: begin
        if (cur_q < NIL) state_d = mqm_pkg::S_P_EVAL;
        else if (last_q) state_d = mqm_pkg::S_IDLE;
        else state_d = mqm_pkg::S_PQ_LOAD;
      end
      mqm_pkg::S_P_EVAL: begin
        if (match) state_d = mqm_pkg::S_P_FREE;
        else state_d = mqm_pkg::S_P_RD;
      end
      mqm_pkg::S_P_FREE:    state_d = mqm_pkg::S_P_RD;
      default:              state_d = mqm_pkg::S_IDLE;
    endcase
  end

  // memory ports, result and datapath registers
  always_comb begin
    free_head_d = free_head_q;
    unused_d    = unused_q;
    qv_d        = qv_q;
    q_d         = q_q;
    h_d         = h_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    head_d      = head_q;
    tail_d      = tail_q;

    link_we_o    = 1'b0;
    link_waddr_o = '0;
    link_wdata_o = NIL;
    link_raddr_o = '0;
    hnd_we_o     = 1'b0;
    hnd_waddr_o  = '0;
    hnd_wdata_o  = h_q;
    hnd_raddr_o  = '0;
    qt_we_o      = 1'b0;
    qt_waddr_o   = q_q;
    qt_wdata_o   = {tail_q, head_q};
    qt_raddr_o   = q_q;

    res_push_o    = 1'b0;
    res_o.status  = mqm_pkg::ST_OK;
    res_o.handle  = '0;

    unique case (state_q)
      mqm_pkg::S_IDLE: begin
        // read the queue entry and the free head link up front
        qt_raddr_o   = queue_id_i[QW-1:0];
        link_raddr_o = free_head_q[AW-1:0];
        if (accept) begin
          q_d = queue_id_i[QW-1:0];
          h_d = h_in;
          unique case (act)
            mqm_pkg::ACT_SEND: begin
              if (!qid_ok) begin
                res_push_o   = 1'b1;
                res_o.status = mqm_pkg::ST_BADQ;
              end else if (!h_nz) begin
                res_push_o   = 1'b1;
                res_o.status = mqm_pkg::ST_NULL;
              end
            end
            mqm_pkg::ACT_RECV: begin
              if (!qid_ok) begin
                res_push_o   = 1'b1;
                res_o.status = mqm_pkg::ST_BADQ;
              end
            end
            mqm_pkg::ACT_PURGE: begin
              q_d        = '0;
              qt_raddr_o = '0;
              if (!h_nz) begin
                res_push_o   = 1'b1;
                res_o.status = mqm_pkg::ST_NULL;
              end
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end

      mqm_pkg::S_SEND: begin
        if (!avail) begin
          res_push_o   = 1'b1;
          res_o.status = mqm_pkg::ST_FULL;
        end else begin
          hnd_we_o     = 1'b1;
          hnd_waddr_o  = send_e[AW-1:0];
          hnd_wdata_o  = h_q;
          link_we_o    = 1'b1;
          link_waddr_o = send_e[AW-1:0];
          link_wdata_o = NIL;
          if (fh_live) free_head_d = link_rdata_i;
          else unused_d = unused_q + LW'(1);
          qt_we_o       = 1'b1;
          qv_d[q_q]     = 1'b1;
          if ((rd_head < NIL) && (rd_tail < NIL)) begin
            qt_wdata_o = {send_e, rd_head};
            cur_d      = send_e;
            tail_d     = rd_tail;
          end else begin
            qt_wdata_o = {send_e, send_e};
            res_push_o = 1'b1;
          end
        end
      end

      mqm_pkg::S_LINK: begin
        // chain the old tail to the new entry
        link_we_o    = 1'b1;
        link_waddr_o = tail_q[AW-1:0];
        link_wdata_o = cur_q;
        res_push_o   = 1'b1;
      end

      mqm_pkg::S_RECV_HEAD: begin
        if (rd_head < NIL) begin
          link_raddr_o = rd_head[AW-1:0];
          hnd_raddr_o  = rd_head[AW-1:0];
          cur_d        = rd_head;
          tail_d       = rd_tail;
        end else begin
          res_push_o   = 1'b1;
          res_o.status = mqm_pkg::ST_EMPTY;
        end
      end

      mqm_pkg::S_RECV_POP: begin
        qt_we_o      = 1'b1;
        qv_d[q_q]    = 1'b1;
        qt_wdata_o   = {(link_rdata_i < NIL) ? tail_q : NIL, link_rdata_i};
        link_we_o    = 1'b1;
        link_waddr_o = cur_q[AW-1:0];
        link_wdata_o = free_head_q;
        free_head_d  = cur_q;
        res_push_o   = 1'b1;
        res_o.handle = mqm_pkg::OUT_HANDLE_W'(hnd_rdata_i);
      end

      mqm_pkg::S_PQ_LOAD: begin
        head_d = rd_head;
        tail_d = rd_tail;
        cur_d  = rd_head;
        prev_d = NIL;
      end

      mqm_pkg::S_P_RD: begin
        if (cur_q < NIL) begin
          link_raddr_o = cur_q[AW-1:0];
          hnd_raddr_o  = cur_q[AW-1:0];
        end else begin
          // end of this queue: write back head and tail
          qt_we_o    = 1'b1;
          qv_d[q_q]  = 1'b1;
          qt_wdata_o = {tail_q, head_q};
          if (last_q) begin
            res_push_o = 1'b1;
          end else begin
            q_d        = q_q + QW'(1);
            qt_raddr_o = q_q + QW'(1);
          end
        end
      end

      mqm_pkg::S_P_EVAL: begin
        if (match) begin
          nxt_d = link_rdata_i;
          if (prev_q < NIL) begin
            link_we_o    = 1'b1;
            link_waddr_o = prev_q[AW-1:0];
            link_wdata_o = link_rdata_i;
          end else begin
            head_d = link_rdata_i;
          end
          if (!(link_rdata_i < NIL)) tail_d = prev_q;
        end else begin
          prev_d = cur_q;
          cur_d  = link_rdata_i;
        end
      end

      mqm_pkg::S_P_FREE: begin
        // release the unlinked entry onto the free list
        link_we_o    = 1'b1;
        link_waddr_o = cur_q[AW-1:0];
        link_wdata_o = free_head_q;
        free_head_d  = cur_q;
        cur_d        = nxt_q;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mqm_pkg::S_IDLE;
      free_head_q <= NIL;
      unused_q    <= '0;
      qv_q        <= '0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      unused_q    <= unused_d;
      qv_q        <= qv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    h_q    <= h_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    nxt_q  <= nxt_d;
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

`default_nettype wire

>>> rtl/mqm_outq.sv
// ----------------------------------------------------------------------------
// mqm_outq
// Result stage: a holding register behind the sequencer and the output
// register of the result stream, so a new request can start while a result
// waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mqm_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mqm_pkg::result_t  res_i,
  output logic                   room_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output mqm_pkg::result_t       m_res_o
);

  logic             pend_v_q, pend_v_d;
  mqm_pkg::result_t pend_q, pend_d;
  logic             out_v_q, out_v_d;
  mqm_pkg::result_t out_q, out_d;
  logic             move;

  assign move   = pend_v_q && (!out_v_q || m_ready_i);
  assign room_o = !pend_v_q || move;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q;
    out_d    = out_q;
    if (move) begin
      out_v_d  = 1'b1;
      out_d    = pend_q;
      pend_v_d = 1'b0;
    end else if (m_ready_i) begin
      out_v_d = 1'b0;
    end
    if (push_i) begin
      pend_v_d = 1'b1;
      pend_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign m_valid_o = out_v_q;
  assign m_res_o   = out_q;

endmodule

`default_nettype wire

>>> rtl/multi_queue_mailbox.sv
// ----------------------------------------------------------------------------
// multi_queue_mailbox
// Per-destination FIFOs of message handles, kept as linked lists in one
// shared entry pool with a free list; send, receive and purge requests.
// ----------------------------------------------------------------------------
// Steps: send runs S_SEND, plus S_LINK if the queue holds entries; receive runs
//   S_RECV_HEAD, plus S_RECV_POP if the queue is not empty; a rejected request
//   ends in S_IDLE. Purge runs S_PQ_LOAD per queue, S_P_RD and S_P_EVAL per entry,
//   S_P_FREE per removed entry; each hop waits on the registered next-link read.
// Result path: a result passes the holding register, then the output register
//   of mqm_outq before it shows on the master side.
// Reset: queues, free list and bump mark are empty at once; no clearing pass.
`default_nettype none

module multi_queue_mailbox #(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [1:0] action, [9:2] queue_id,
                                            // [25:10] msg_handle, [31:26] zero
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o   // [2:0] status, [18:3] out_handle,
                                            // [23:19] zero
);

  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // sequencer to result stage
  logic             res_room;
  logic             res_push;
  mqm_pkg::result_t res;
  mqm_pkg::result_t m_res;

  // pool link memory: next pointer of each entry (ENTRIES means null)
  logic                   link_we;
  logic [AW-1:0]          link_waddr, link_raddr;
  logic [LW-1:0]          link_wdata, link_rdata;

  // pool handle memory: handle held by each entry
  logic                   hnd_we;
  logic [AW-1:0]          hnd_waddr, hnd_raddr;
  logic [HANDLE_BITS-1:0] hnd_wdata, hnd_rdata;

  // queue table: {tail, head} per queue, validated by per-queue bits
  logic                   qt_we;
  logic [QW-1:0]          qt_waddr, qt_raddr;
  logic [2*LW-1:0]        qt_wdata, qt_rdata;

  mqm_seq #(
    .NUM_QUEUES  (NUM_QUEUES),
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .action_i     (s_axis_tdata_i[1:0]),
    .queue_id_i   (s_axis_tdata_i[9:2]),
    .msg_handle_i (s_axis_tdata_i[25:10]),
    .res_room_i   (res_room),
    .res_push_o   (res_push),
    .res_o        (res),
    .link_we_o    (link_we),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .link_raddr_o (link_raddr),
    .link_rdata_i (link_rdata),
    .hnd_we_o     (hnd_we),
    .hnd_waddr_o  (hnd_waddr),
    .hnd_wdata_o  (hnd_wdata),
    .hnd_raddr_o  (hnd_raddr),
    .hnd_rdata_i  (hnd_rdata),
    .qt_we_o      (qt_we),
    .qt_waddr_o   (qt_waddr),
    .qt_wdata_o   (qt_wdata),
    .qt_raddr_o   (qt_raddr),
    .qt_rdata_i   (qt_rdata)
  );

  // Pool memories: the sequencer never reads an entry in the cycle it
  // writes it, so no bypass is needed.
  mqm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  mqm_ram #(.WIDTH(HANDLE_BITS), .DEPTH(ENTRIES)) u_hnd_ram (
    .clk_i   (clk_i),
    .we_i    (hnd_we),
    .waddr_i (hnd_waddr),
    .wdata_i (hnd_wdata),
    .raddr_i (hnd_raddr),
    .rdata_o (hnd_rdata)
  );

  mqm_ram #(.WIDTH(2 * LW), .DEPTH(NUM_QUEUES)) u_qt_ram (
    .clk_i   (clk_i),
    .we_i    (qt_we),
    .waddr_i (qt_waddr),
    .wdata_i (qt_wdata),
    .raddr_i (qt_raddr),
    .rdata_o (qt_rdata)
  );

  // Result stage: hold one finished result while another waits on the port.
  mqm_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res_push),
    .res_i     (res),
    .room_o    (res_room),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = {5'b0, m_res.handle, m_res.status};

  // The sequencer only finishes a request when the result stage has room.
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> res_room)
    else $error("result pushed into a full result stage");

  // A popped handle comes only with success status.
  a_handle_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_res.handle != '0)) |-> (m_res.status == mqm_pkg::ST_OK))
    else $error("nonzero handle with failure status");

  // Link memory writes stay inside the entry pool.
  a_link_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_we |-> ({1'b0, link_waddr} < (AW + 1)'(ENTRIES)))
    else $error("link write outside the entry pool");

endmodule

`default_nettype wire
